// ===== design/mlat_pkg.sv =====
// Package for the multi-LED action timer: sizes, codes, entry layout and
// sequencer states. Depends on nothing; the top level imports it.
`default_nettype none

package mlat_pkg;

    localparam int LED_COUNT  = 8;
    localparam int LED_IDX_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int IN_IDX_W   = 4;
    localparam int DELAY_W    = 16;
    localparam int OUT_LED_W  = 8;
    localparam int EXT_W      = (LED_COUNT > OUT_LED_W) ? LED_COUNT : OUT_LED_W;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ON     = 2'd1,
        ACT_OFF    = 2'd2,
        ACT_TOGGLE = 2'd3
    } t_action;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_action              act;
        logic [DELAY_W-1:0]   cnt;
        logic [DELAY_W-1:0]   reload;
        logic                 cont;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== design/mlat_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module mlat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/multi_led_action_timer.sv =====
// Top level of the multi-LED action timer: command decode, tick walk over the
// entry RAM, LED levels and result register. Depends on mlat_pkg and mlat_ram.
//
//   Channel  Dir  Handshake             Payload
//   s        in   i_s_tvalid/o_s_tready i_s_tdata, i_s_tuser (command)
//   m        out  o_m_tvalid/i_m_tready o_m_tdata
//
// A set command passes through ST_OUT only; a tick walks every entry in ST_WALK,
// reading and writing back one RAM entry per cycle, then passes ST_DRAIN and ST_OUT.
// Reset clears the valid bits of all entries at once, so there is no clearing pass.
// A new beat is taken once the previous one has been processed, even while its
// result still waits in the output register; a stalled output only holds the
// final load of the next result.
`default_nettype none

module multi_led_action_timer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // led_index[3:0], action[5:4], delay_ticks[21:6], repeat_mode[22], zero[23]
    input  logic [mlat_pkg::S_TDATA_W-1:0] i_s_tdata,
    // command[0]
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // led_levels[7:0], changed_mask[15:8]
    output logic [mlat_pkg::M_TDATA_W-1:0] o_m_tdata
);

    import mlat_pkg::*;

    t_state                 r_state, n_state;
    logic [LED_IDX_W-1:0]   r_idx, n_idx;
    logic                   r_wb_vld;
    logic [LED_IDX_W-1:0]   r_wb_idx;
    logic                   r_rd_vq;
    logic [LED_COUNT-1:0]   r_valid;
    logic [LED_COUNT-1:0]   r_level, n_level;
    logic [LED_COUNT-1:0]   r_mask, n_mask;
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;

    logic                   s_acc;
    logic                   walking;
    logic                   out_load;
    logic [IN_IDX_W-1:0]    s_idx;
    t_action                s_act;
    logic [DELAY_W-1:0]     s_delay;
    logic                   s_rep;
    logic                   set_wr;
    t_entry                 set_ent;
    t_entry                 rd_ent;
    t_entry                 ent;
    t_entry                 wb_ent;
    logic                   fire;
    logic                   new_lvl;
    logic                   ram_we;
    logic [LED_IDX_W-1:0]   ram_waddr;
    t_entry                 ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [EXT_W-1:0]       lvl_ext;
    logic [EXT_W-1:0]       mask_ext;

    assign s_idx   = i_s_tdata[3:0];
    assign s_act   = t_action'(i_s_tdata[5:4]);
    assign s_delay = i_s_tdata[21:6];
    assign s_rep   = i_s_tdata[22];

    assign s_acc  = i_s_tvalid && o_s_tready;
    assign set_wr = s_acc && (t_cmd'(i_s_tuser) == CMD_SET)
                    && ({1'b0, s_idx} < (IN_IDX_W + 1)'(LED_COUNT));

    always_comb begin
        set_ent.act    = s_act;
        set_ent.cnt    = s_delay;
        set_ent.reload = s_delay;
        set_ent.cont   = s_rep;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = (t_cmd'(i_s_tuser) == CMD_TICK) ? ST_WALK : ST_OUT;
                end
            end
            ST_WALK: begin
                if (r_idx == LED_IDX_W'(LED_COUNT - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_s_tready = 1'b0;
        walking    = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE:  o_s_tready = 1'b1;
            ST_WALK:  walking    = 1'b1;
            ST_DRAIN: walking    = 1'b0;
            ST_OUT:   out_load   = !r_out_valid || i_m_tready;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (s_acc) begin
            n_idx = '0;
        end else if (walking) begin
            n_idx = r_idx + LED_IDX_W'(1);
        end
    end

    assign rd_ent = t_entry'(ram_rdata);
    assign ent    = r_rd_vq ? rd_ent : t_entry'('0);

    // Read-modify-write of the entry read in the previous cycle.
    always_comb begin
        wb_ent  = ent;
        fire    = 1'b0;
        new_lvl = r_level[r_wb_idx];
        if (ent.act != ACT_NONE) begin
            if (ent.cnt != '0) begin
                wb_ent.cnt = ent.cnt - DELAY_W'(1);
            end else begin
                fire = 1'b1;
                case (ent.act)
                    ACT_ON:  new_lvl = 1'b1;
                    ACT_OFF: new_lvl = 1'b0;
                    default: new_lvl = !r_level[r_wb_idx];
                endcase
                if (ent.cont) begin
                    wb_ent.cnt = ent.reload - DELAY_W'(1);
                end else begin
                    wb_ent.act = ACT_NONE;
                end
            end
        end
    end

    always_comb begin
        n_level = r_level;
        n_mask  = r_mask;
        if (s_acc) begin
            n_mask = '0;
        end else if (r_wb_vld) begin
            n_level[r_wb_idx] = new_lvl;
            n_mask[r_wb_idx]  = r_mask[r_wb_idx] | fire;
        end
    end

    assign ram_we    = set_wr || r_wb_vld;
    assign ram_waddr = set_wr ? s_idx[LED_IDX_W-1:0] : r_wb_idx;
    assign ram_wdata = set_wr ? set_ent : wb_ent;

    mlat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LED_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign lvl_ext  = EXT_W'(r_level);
    assign mask_ext = EXT_W'(r_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_wb_vld    <= 1'b0;
            r_valid     <= '0;
            r_level     <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_wb_vld <= walking;
            r_level  <= n_level;
            r_mask   <= n_mask;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_idx <= r_idx;
        r_rd_vq  <= r_valid[r_idx];
        if (out_load) begin
            r_out_data <= {mask_ext[OUT_LED_W-1:0], lvl_ext[OUT_LED_W-1:0]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_wb_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> $past(r_state) == ST_WALK)
        else $error("write-back without a preceding walk read");

    a_mask_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_mask == '0)
        else $error("fired mask not cleared on a new beat");

    a_out_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT |-> !r_wb_vld)
        else $error("result loaded before the last write-back");

    a_no_set_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_wr |-> !r_wb_vld)
        else $error("set write collides with a walk write-back");

endmodule

`default_nettype wire
